[rtl/core/tttm_pkg.sv]
`default_nettype none

package tttm_pkg;

   // Fixed-point format: ONE means 1.0.
   localparam int FRAC_BITS = 12;
   localparam int ONE       = 1 << FRAC_BITS;
   localparam int HALF      = ONE / 2;

   // Field widths.
   localparam int DEM_W   = 16;
   localparam int THR_W   = 13;
   localparam int GAIN_W  = 14;
   localparam int PULSE_W = 12;
   localparam int TILT_W  = 16;
   localparam int SUM_W   = DEM_W + 1;

   // Internal widths.
   localparam int SC_W  = SUM_W + GAIN_W + 1 - FRAC_BITS;   // gain-scaled axes
   localparam int THS_W = THR_W + GAIN_W + 1 - FRAC_BITS;   // gain-scaled throttle
   localparam int ANG_W = FRAC_BITS + 4;                    // tilt angle
   localparam int W_W   = ANG_W + 1;                        // pitch weights
   localparam int M_W   = SC_W + 4;                         // mixed products
   localparam int CQ_W  = FRAC_BITS + 1;                    // mixing coefficients
   localparam int Y_W   = M_W + 1;                          // reduced yaw
   localparam int T_W   = M_W + 2;                          // thrust and tilt sums
   localparam int A_W   = T_W + 1;                          // sums with adjustment

   // Product widths.
   localparam int P_SC = SUM_W + GAIN_W + 1;
   localparam int P_TH = THR_W + GAIN_W + 1;
   localparam int P_WS = W_W + SC_W;
   localparam int P_SQ = SC_W + CQ_W;
   localparam int P_AQ = ANG_W + CQ_W;
   localparam int P_MQ = M_W + CQ_W;
   localparam int P_YQ = Y_W + CQ_W;

   // Tilt angle: floor((pulse * 2 * ONE + 500) / 1000) - 3 * ONE, the divide
   // done as a multiply by a rounded-up reciprocal.
   localparam int ANG_NB = PULSE_W + FRAC_BITS + 2;
   localparam int ANG_SH = ANG_NB + 10;
   localparam int ANG_PW = 2 * ANG_NB + 1;
   localparam logic [ANG_NB:0] ANG_RECIP =
      (ANG_NB + 1)'(((64'd1 << ANG_SH) + 64'd999) / 64'd1000);
   localparam logic [ANG_NB-1:0] ANG_RND = ANG_NB'(500);
   localparam logic signed [ANG_W-1:0] ANG_BASE = ANG_W'(3 * ONE);

   // Mixing coefficients, rounded to nearest.
   localparam logic signed [CQ_W-1:0] Q02  = CQ_W'((2 * ONE * 2 + 10) / 20);
   localparam logic signed [CQ_W-1:0] Q03  = CQ_W'((3 * ONE * 2 + 10) / 20);
   localparam logic signed [CQ_W-1:0] Q04  = CQ_W'((4 * ONE * 2 + 10) / 20);
   localparam logic signed [CQ_W-1:0] Q045 = CQ_W'((45 * ONE * 2 + 100) / 200);
   localparam logic signed [CQ_W-1:0] Q05  = CQ_W'((5 * ONE * 2 + 10) / 20);
   localparam logic signed [CQ_W-1:0] Q06  = CQ_W'((6 * ONE * 2 + 10) / 20);
   localparam logic signed [CQ_W-1:0] Q07  = CQ_W'((7 * ONE * 2 + 10) / 20);

   // Divider widths.
   localparam int MAG_W  = TILT_W + 1;
   localparam int N_W    = MAG_W + FRAC_BITS;
   localparam int Q_BITS = TILT_W;
   localparam int TOP_W  = N_W - Q_BITS;
   localparam int REM_W  = (TOP_W > GAIN_W) ? TOP_W + 1 : GAIN_W + 1;

   // One demand set.
   typedef struct packed {
      logic signed [DEM_W-1:0] roll_demand;
      logic signed [DEM_W-1:0] roll_feedforward;
      logic signed [DEM_W-1:0] pitch_demand;
      logic signed [DEM_W-1:0] pitch_feedforward;
      logic signed [DEM_W-1:0] yaw_demand;
      logic signed [DEM_W-1:0] yaw_feedforward;
      logic [THR_W-1:0]        throttle_demand;
      logic [THR_W-1:0]        throttle_ceiling;
      logic [GAIN_W-1:0]       supply_gain;
      logic [PULSE_W-1:0]      tilt_stick_pulse;
   } req_type;

   // Scaled demands and tilt angle.
   typedef struct packed {
      logic signed [SC_W-1:0]  roll;
      logic signed [SC_W-1:0]  pitch;
      logic signed [SC_W-1:0]  yaw;
      logic [THS_W-1:0]        thr;
      logic [THR_W-1:0]        ceil_v;
      logic [GAIN_W-1:0]       gain;
      logic signed [ANG_W-1:0] angle;
   } front_type;

   // Mixed thrusts and tilts, before the throttle divide.
   typedef struct packed {
      logic [THR_W-1:0]         left_thrust;
      logic [THR_W-1:0]         right_thrust;
      logic [THR_W-1:0]         tail_thrust;
      logic signed [TILT_W-1:0] left_tilt;
      logic signed [TILT_W-1:0] right_tilt;
      logic signed [TILT_W-1:0] tail_tilt;
      logic signed [TILT_W-1:0] applied_throttle;
      logic                     throttle_low_hit;
      logic                     throttle_high_hit;
      logic                     attitude_limited;
      logic [GAIN_W-1:0]        gain;
   } mix_type;

   // One result word.
   typedef struct packed {
      logic [THR_W-1:0]         left_thrust;
      logic [THR_W-1:0]         right_thrust;
      logic [THR_W-1:0]         tail_thrust;
      logic signed [TILT_W-1:0] left_tilt;
      logic signed [TILT_W-1:0] right_tilt;
      logic signed [TILT_W-1:0] tail_tilt;
      logic signed [TILT_W-1:0] applied_throttle;
      logic signed [TILT_W-1:0] uncompensated_throttle;
      logic                     throttle_low_hit;
      logic                     throttle_high_hit;
      logic                     attitude_limited;
   } rsp_type;

endpackage

`default_nettype wire

[rtl/core/tilt_tricopter_thrust_mixer_top.sv]
`default_nettype none

// Channel   Direction  Handshake            Word
// req_      in         req_valid/req_stall  one demand set
// rsp_      out        rsp_valid/rsp_stall  thrusts, tilts, throttle, flags
//
// One demand set is taken per cycle unless the result is stalled; each set
// passes two front stages, five mixing stages and an 18-stage divider (load, one
// stage per quotient bit, result register). Reset is synchronous and clears all
// valid bits. A stalled result holds the whole pipeline; one more word is caught
// in an input skid register, and req_stall rises while it is full.

module tilt_tricopter_thrust_mixer_top (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 req_valid,
   output logic                                req_stall,
   input  wire signed [tttm_pkg::DEM_W-1:0]    req_roll_demand,
   input  wire signed [tttm_pkg::DEM_W-1:0]    req_roll_feedforward,
   input  wire signed [tttm_pkg::DEM_W-1:0]    req_pitch_demand,
   input  wire signed [tttm_pkg::DEM_W-1:0]    req_pitch_feedforward,
   input  wire signed [tttm_pkg::DEM_W-1:0]    req_yaw_demand,
   input  wire signed [tttm_pkg::DEM_W-1:0]    req_yaw_feedforward,
   input  wire [tttm_pkg::THR_W-1:0]           req_throttle_demand,
   input  wire [tttm_pkg::THR_W-1:0]           req_throttle_ceiling,
   input  wire [tttm_pkg::GAIN_W-1:0]          req_supply_gain,
   input  wire [tttm_pkg::PULSE_W-1:0]         req_tilt_stick_pulse,
   output logic                                rsp_valid,
   input  wire                                 rsp_stall,
   output logic [tttm_pkg::THR_W-1:0]          rsp_left_thrust,
   output logic [tttm_pkg::THR_W-1:0]          rsp_right_thrust,
   output logic [tttm_pkg::THR_W-1:0]          rsp_tail_thrust,
   output logic signed [tttm_pkg::TILT_W-1:0]  rsp_left_tilt,
   output logic signed [tttm_pkg::TILT_W-1:0]  rsp_right_tilt,
   output logic signed [tttm_pkg::TILT_W-1:0]  rsp_tail_tilt,
   output logic signed [tttm_pkg::TILT_W-1:0]  rsp_applied_throttle,
   output logic signed [tttm_pkg::TILT_W-1:0]  rsp_uncompensated_throttle,
   output logic                                rsp_throttle_low_hit,
   output logic                                rsp_throttle_high_hit,
   output logic                                rsp_attitude_limited
);
   import tttm_pkg::*;

   req_type   req_word;
   req_type   skid_ff;
   logic      skid_valid_ff;
   logic      accept;
   logic      en;
   req_type   pipe_word;
   logic      pipe_valid;
   logic      front_valid, mix_valid, div_valid;
   front_type front_word;
   mix_type   mix_word;
   rsp_type   rsp_word;

   // Gather the input ports into one word.
   always_comb begin
      req_word.roll_demand       = req_roll_demand;
      req_word.roll_feedforward  = req_roll_feedforward;
      req_word.pitch_demand      = req_pitch_demand;
      req_word.pitch_feedforward = req_pitch_feedforward;
      req_word.yaw_demand        = req_yaw_demand;
      req_word.yaw_feedforward   = req_yaw_feedforward;
      req_word.throttle_demand   = req_throttle_demand;
      req_word.throttle_ceiling  = req_throttle_ceiling;
      req_word.supply_gain       = req_supply_gain;
      req_word.tilt_stick_pulse  = req_tilt_stick_pulse;
   end

   // The pipeline moves unless a finished word is held at the output.
   assign en        = !(div_valid && rsp_stall);
   assign req_stall = skid_valid_ff;
   assign accept    = req_valid && !skid_valid_ff;

   // A held skid word enters the pipeline ahead of new input.
   always_comb begin
      if (skid_valid_ff) begin
         pipe_word  = skid_ff;
         pipe_valid = 1'b1;
      end else begin
         pipe_word  = req_word;
         pipe_valid = accept;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         skid_valid_ff <= 1'b0;
      end else if (en) begin
         skid_valid_ff <= 1'b0;
      end else if (accept) begin
         skid_valid_ff <= 1'b1;
      end
      if (!en && accept) begin
         skid_ff <= req_word;
      end
   end

   tttm_front u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (pipe_valid),
      .in_req    (pipe_word),
      .out_valid (front_valid),
      .out_front (front_word)
   );

   tttm_mix u_mix (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (front_valid),
      .in_front  (front_word),
      .out_valid (mix_valid),
      .out_mix   (mix_word)
   );

   tttm_div u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (mix_valid),
      .in_mix    (mix_word),
      .out_valid (div_valid),
      .out_rsp   (rsp_word)
   );

   // Result ports.
   assign rsp_valid                  = div_valid;
   assign rsp_left_thrust            = rsp_word.left_thrust;
   assign rsp_right_thrust           = rsp_word.right_thrust;
   assign rsp_tail_thrust            = rsp_word.tail_thrust;
   assign rsp_left_tilt              = rsp_word.left_tilt;
   assign rsp_right_tilt             = rsp_word.right_tilt;
   assign rsp_tail_tilt              = rsp_word.tail_tilt;
   assign rsp_applied_throttle       = rsp_word.applied_throttle;
   assign rsp_uncompensated_throttle = rsp_word.uncompensated_throttle;
   assign rsp_throttle_low_hit       = rsp_word.throttle_low_hit;
   assign rsp_throttle_high_hit      = rsp_word.throttle_high_hit;
   assign rsp_attitude_limited       = rsp_word.attitude_limited;

endmodule

`default_nettype wire

[rtl/core/tttm_front.sv]
`default_nettype none

module tttm_front (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  en,
   input  wire                  in_valid,
   input  tttm_pkg::req_type    in_req,
   output logic                 out_valid,
   output tttm_pkg::front_type  out_front
);
   import tttm_pkg::*;

   // Stage one registers: axis sums, raw inputs and the angle product.
   logic signed [SUM_W-1:0] roll_ff, pitch_ff, yaw_ff;
   logic signed [SUM_W-1:0] roll_in, pitch_in, yaw_in;
   logic [THR_W-1:0]        thr_ff, ceil_ff;
   logic [GAIN_W-1:0]       gain_ff;
   logic [ANG_PW-1:0]       aprod_ff, aprod_in;
   logic                    s1_valid_ff;
   logic [ANG_NB-1:0]       ang_num;

   // Stage two.
   logic signed [P_SC-1:0]  roll_p, pitch_p, yaw_p;
   logic [P_TH-1:0]         thr_p;
   logic signed [ANG_W-1:0] angle;
   logic signed [GAIN_W:0]  gain_s;
   front_type               front_ff, front_in;
   logic                    s2_valid_ff;

   // Demand plus feedforward, and the pulse numerator times the reciprocal.
   always_comb begin
      roll_in  = SUM_W'(in_req.roll_demand) + SUM_W'(in_req.roll_feedforward);
      pitch_in = SUM_W'(in_req.pitch_demand) + SUM_W'(in_req.pitch_feedforward);
      yaw_in   = SUM_W'(in_req.yaw_demand) + SUM_W'(in_req.yaw_feedforward);
      ang_num  = {1'b0, in_req.tilt_stick_pulse, {(FRAC_BITS + 1){1'b0}}} + ANG_RND;
      aprod_in = ANG_PW'(ang_num) * ANG_PW'(ANG_RECIP);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= in_valid;
      end
      if (en) begin
         roll_ff  <= roll_in;
         pitch_ff <= pitch_in;
         yaw_ff   <= yaw_in;
         thr_ff   <= in_req.throttle_demand;
         ceil_ff  <= in_req.throttle_ceiling;
         gain_ff  <= in_req.supply_gain;
         aprod_ff <= aprod_in;
      end
   end

   // Gain scaling with round to nearest, and the tilt angle.
   always_comb begin
      gain_s  = $signed({1'b0, gain_ff});
      roll_p  = P_SC'(roll_ff) * P_SC'(gain_s) + P_SC'(HALF);
      pitch_p = P_SC'(pitch_ff) * P_SC'(gain_s) + P_SC'(HALF);
      yaw_p   = P_SC'(yaw_ff) * P_SC'(gain_s) + P_SC'(HALF);
      thr_p   = P_TH'(thr_ff) * P_TH'(gain_ff) + P_TH'(HALF);
      angle   = $signed(aprod_ff[ANG_SH +: ANG_W]) - ANG_BASE;
      front_in.roll   = roll_p[FRAC_BITS +: SC_W];
      front_in.pitch  = pitch_p[FRAC_BITS +: SC_W];
      front_in.yaw    = yaw_p[FRAC_BITS +: SC_W];
      front_in.thr    = thr_p[FRAC_BITS +: THS_W];
      front_in.ceil_v = ceil_ff;
      front_in.gain   = gain_ff;
      front_in.angle  = angle;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (en) begin
         s2_valid_ff <= s1_valid_ff;
      end
      if (en) begin
         front_ff <= front_in;
      end
   end

   assign out_valid = s2_valid_ff;
   assign out_front = front_ff;

endmodule

`default_nettype wire

[rtl/core/tttm_mix.sv]
`default_nettype none

module tttm_mix (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  en,
   input  wire                  in_valid,
   input  tttm_pkg::front_type  in_front,
   output logic                 out_valid,
   output tttm_pkg::mix_type    out_mix
);
   import tttm_pkg::*;

   localparam logic signed [A_W-1:0] S_MAX = A_W'((1 << (TILT_W - 1)) - 1);
   localparam logic signed [A_W-1:0] S_MIN = -S_MAX - A_W'(1);

   function automatic logic signed [TILT_W-1:0] sat_tilt(input logic signed [A_W-1:0] v);
      logic signed [A_W-1:0] r;
      r = v;
      if (v > S_MAX) begin
         r = S_MAX;
      end else if (v < S_MIN) begin
         r = S_MIN;
      end
      return r[TILT_W-1:0];
   endfunction

   function automatic logic [THR_W-1:0] clamp_unit(input logic signed [A_W-1:0] v);
      logic signed [A_W-1:0] r;
      r = v;
      if (v < A_W'(0)) begin
         r = A_W'(0);
      end else if (v > A_W'(ONE)) begin
         r = A_W'(ONE);
      end
      return r[THR_W-1:0];
   endfunction

   logic [4:0] valid_ff;

   // Stage three: weights, throttle clamp, first products.
   logic signed [W_W-1:0]  sw, mw;
   logic [THR_W-1:0]       thr_z, thr_c_in;
   logic                   low_in, high_in;
   logic signed [P_WS-1:0] mp_p, sp_p, sy_p;
   logic signed [P_SQ-1:0] r45_p;
   logic signed [P_AQ-1:0] a70_p;
   logic signed [M_W-1:0]  mp_ff, sp_ff, sy_ff;
   logic signed [SC_W-1:0] r45_ff, yaw3_ff;
   logic signed [ANG_W-1:0] a70_ff;
   logic [THR_W-1:0]       thr3_ff;
   logic                   low3_ff, high3_ff, le3_ff;
   logic [GAIN_W-1:0]      gain3_ff;

   always_comb begin
      sw = (in_front.angle < 0) ? -W_W'(in_front.angle) : W_W'(in_front.angle);
      mw = W_W'(ONE) - sw;
      low_in  = (in_front.thr == '0);
      thr_z   = low_in ? '0 : in_front.thr[THR_W-1:0];
      high_in = (THS_W'(thr_z) >= THS_W'(in_front.ceil_v)) || (!low_in &&
                (in_front.thr >= THS_W'(in_front.ceil_v)));
      thr_c_in = high_in ? in_front.ceil_v : thr_z;
      mp_p  = P_WS'(mw) * P_WS'(in_front.pitch) + P_WS'(HALF);
      sp_p  = P_WS'(sw) * P_WS'(in_front.pitch) + P_WS'(HALF);
      sy_p  = P_WS'(sw) * P_WS'(in_front.yaw) + P_WS'(HALF);
      r45_p = P_SQ'(in_front.roll) * P_SQ'(Q045) + P_SQ'(HALF);
      a70_p = P_AQ'(in_front.angle) * P_AQ'(Q07) + P_AQ'(HALF);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mp_ff    <= mp_p[FRAC_BITS +: M_W];
         sp_ff    <= sp_p[FRAC_BITS +: M_W];
         sy_ff    <= sy_p[FRAC_BITS +: M_W];
         r45_ff   <= r45_p[FRAC_BITS +: SC_W];
         a70_ff   <= a70_p[FRAC_BITS +: ANG_W];
         yaw3_ff  <= in_front.yaw;
         thr3_ff  <= thr_c_in;
         low3_ff  <= low_in;
         high3_ff <= high_in;
         le3_ff   <= (in_front.angle <= 0);
         gain3_ff <= in_front.gain;
      end
   end

   // Stage four: coefficient products, picked by the sign of the tilt.
   logic signed [CQ_W-1:0] c_lr, c_t;
   logic signed [P_MQ-1:0] mp4_p, mp6_p, splr_p, spt_p, sy4_p;
   logic signed [M_W-1:0]  mp4_ff, mp6_ff, splr_ff, spt_ff, sy4_ff;
   logic signed [SC_W-1:0] r45_4_ff, yaw4_ff;
   logic signed [ANG_W-1:0] a70_4_ff;
   logic [THR_W-1:0]       thr4_ff;
   logic                   low4_ff, high4_ff, le4_ff;
   logic [GAIN_W-1:0]      gain4_ff;

   always_comb begin
      c_lr   = le3_ff ? Q02 : Q03;
      c_t    = le3_ff ? Q05 : Q04;
      mp4_p  = P_MQ'(mp_ff) * P_MQ'(Q04) + P_MQ'(HALF);
      mp6_p  = P_MQ'(mp_ff) * P_MQ'(Q06) + P_MQ'(HALF);
      splr_p = P_MQ'(sp_ff) * P_MQ'(c_lr) + P_MQ'(HALF);
      spt_p  = P_MQ'(sp_ff) * P_MQ'(c_t) + P_MQ'(HALF);
      sy4_p  = P_MQ'(sy_ff) * P_MQ'(Q04) + P_MQ'(HALF);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mp4_ff   <= mp4_p[FRAC_BITS +: M_W];
         mp6_ff   <= mp6_p[FRAC_BITS +: M_W];
         splr_ff  <= splr_p[FRAC_BITS +: M_W];
         spt_ff   <= spt_p[FRAC_BITS +: M_W];
         sy4_ff   <= sy4_p[FRAC_BITS +: M_W];
         r45_4_ff <= r45_ff;
         yaw4_ff  <= yaw3_ff;
         a70_4_ff <= a70_ff;
         thr4_ff  <= thr3_ff;
         low4_ff  <= low3_ff;
         high4_ff <= high3_ff;
         le4_ff   <= le3_ff;
         gain4_ff <= gain3_ff;
      end
   end

   // Stage five: thrust sums, reduced yaw and partial tilt sums.
   logic signed [T_W-1:0] thr_s4, tl_in, tr_in, tt_in, al_in, ar_in, at_in;
   logic signed [Y_W-1:0] yaw2_in;
   logic signed [T_W-1:0] tl5_ff, tr5_ff, tt5_ff, al5_ff, ar5_ff, at5_ff;
   logic signed [Y_W-1:0] yaw5_ff;
   logic [THR_W-1:0]      thr5_ff;
   logic                  low5_ff, high5_ff;
   logic [GAIN_W-1:0]     gain5_ff;

   always_comb begin
      thr_s4  = T_W'($signed({1'b0, thr4_ff}));
      tl_in   = thr_s4 + T_W'(mp4_ff) - T_W'(r45_4_ff);
      tr_in   = thr_s4 + T_W'(mp4_ff) + T_W'(r45_4_ff);
      tt_in   = thr_s4 - T_W'(mp6_ff);
      yaw2_in = Y_W'(yaw4_ff) - Y_W'(sy4_ff);
      if (le4_ff) begin
         al_in = -T_W'(a70_4_ff) - T_W'(splr_ff);
         ar_in = T_W'(a70_4_ff) + T_W'(splr_ff);
         at_in = T_W'(a70_4_ff) - T_W'(spt_ff);
      end else begin
         al_in = -T_W'(a70_4_ff) + T_W'(splr_ff);
         ar_in = T_W'(a70_4_ff) - T_W'(splr_ff);
         at_in = T_W'(a70_4_ff) + T_W'(spt_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         tl5_ff   <= tl_in;
         tr5_ff   <= tr_in;
         tt5_ff   <= tt_in;
         al5_ff   <= al_in;
         ar5_ff   <= ar_in;
         at5_ff   <= at_in;
         yaw5_ff  <= yaw2_in;
         thr5_ff  <= thr4_ff;
         low5_ff  <= low4_ff;
         high5_ff <= high4_ff;
         gain5_ff <= gain4_ff;
      end
   end

   // Stage six: yaw share of the side tilts, and the thrust excess.
   logic signed [P_YQ-1:0] y3_p;
   logic signed [T_W-1:0]  tmax;
   logic                   over_in;
   logic signed [A_W-1:0]  adj_in;
   logic signed [Y_W-1:0]  y3_ff;
   logic signed [A_W-1:0]  adj_ff;
   logic signed [T_W-1:0]  tl6_ff, tr6_ff, tt6_ff, al6_ff, ar6_ff, at6_ff;
   logic [THR_W-1:0]       thr6_ff;
   logic                   low6_ff, high6_ff, att6_ff;
   logic [GAIN_W-1:0]      gain6_ff;

   always_comb begin
      y3_p    = P_YQ'(yaw5_ff) * P_YQ'(Q03) + P_YQ'(HALF);
      tmax    = (tr5_ff > tl5_ff) ? tr5_ff : tl5_ff;
      over_in = (tmax > T_W'(ONE));
      adj_in  = over_in ? (A_W'(ONE) - A_W'(tmax)) : A_W'(0);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         y3_ff    <= y3_p[FRAC_BITS +: Y_W];
         adj_ff   <= adj_in;
         tl6_ff   <= tl5_ff;
         tr6_ff   <= tr5_ff;
         tt6_ff   <= tt5_ff;
         al6_ff   <= al5_ff;
         ar6_ff   <= ar5_ff;
         at6_ff   <= at5_ff;
         thr6_ff  <= thr5_ff;
         low6_ff  <= low5_ff;
         high6_ff <= high5_ff | over_in;
         att6_ff  <= over_in;
         gain6_ff <= gain5_ff;
      end
   end

   // Stage seven: apply the adjustment, clamp and saturate.
   mix_type mix_in, mix_ff;

   always_comb begin
      mix_in.left_thrust       = clamp_unit(A_W'(tl6_ff) + adj_ff);
      mix_in.right_thrust      = clamp_unit(A_W'(tr6_ff) + adj_ff);
      mix_in.tail_thrust       = clamp_unit(A_W'(tt6_ff) + adj_ff);
      mix_in.left_tilt         = sat_tilt(A_W'(al6_ff) - A_W'(y3_ff));
      mix_in.right_tilt        = sat_tilt(A_W'(ar6_ff) - A_W'(y3_ff));
      mix_in.tail_tilt         = sat_tilt(A_W'(at6_ff));
      mix_in.applied_throttle  = sat_tilt(A_W'($signed({1'b0, thr6_ff})) + adj_ff);
      mix_in.throttle_low_hit  = low6_ff;
      mix_in.throttle_high_hit = high6_ff;
      mix_in.attitude_limited  = att6_ff;
      mix_in.gain              = gain6_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mix_ff <= mix_in;
      end
   end

   // Valid bits follow the five stages.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[3:0], in_valid};
      end
   end

   assign out_valid = valid_ff[4];
   assign out_mix   = mix_ff;

endmodule

`default_nettype wire

[rtl/core/tttm_div.sv]
`default_nettype none

module tttm_div (
   input  wire                clock,
   input  wire                reset,
   input  wire                en,
   input  wire                in_valid,
   input  tttm_pkg::mix_type  in_mix,
   output logic               out_valid,
   output tttm_pkg::rsp_type  out_rsp
);
   import tttm_pkg::*;

   localparam logic signed [TILT_W-1:0] T_MAX = TILT_W'((1 << (TILT_W - 1)) - 1);
   localparam logic signed [TILT_W-1:0] T_MIN = -T_MAX - TILT_W'(1);

   // Restoring divider, one quotient bit per stage. Stage zero loads the
   // magnitude of applied throttle times ONE and flags a quotient too
   // large for the result.
   logic [REM_W-1:0]  rem_ff  [0:Q_BITS];
   logic [Q_BITS-1:0] low_ff  [0:Q_BITS];
   logic [Q_BITS-1:0] quo_ff  [0:Q_BITS];
   logic [GAIN_W-1:0] div_ff  [0:Q_BITS];
   logic              ovf_ff  [0:Q_BITS];
   logic              neg_ff  [0:Q_BITS];
   mix_type           pay_ff  [0:Q_BITS];
   logic [Q_BITS:0]   valid_ff;

   logic [REM_W-1:0]  rem_in  [1:Q_BITS];
   logic [Q_BITS-1:0] low_in  [1:Q_BITS];
   logic [Q_BITS-1:0] quo_in  [1:Q_BITS];

   logic [MAG_W-1:0]  mag;
   logic [N_W-1:0]    num;
   logic [GAIN_W-1:0] div0;
   logic [REM_W-1:0]  rem0;

   always_comb begin
      mag  = in_mix.applied_throttle[TILT_W-1] ? -MAG_W'(in_mix.applied_throttle)
                                                :  MAG_W'(in_mix.applied_throttle);
      num  = {mag, {FRAC_BITS{1'b0}}};
      div0 = (in_mix.gain == '0) ? GAIN_W'(1) : in_mix.gain;
      rem0 = REM_W'(num[N_W-1:Q_BITS]);
   end

   // One shift and trial subtract per stage.
   always_comb begin
      logic [REM_W-1:0] trial;
      logic             fit;
      for (int i = 1; i <= Q_BITS; i++) begin
         trial     = {rem_ff[i-1][REM_W-2:0], low_ff[i-1][Q_BITS-1]};
         fit       = (trial >= REM_W'(div_ff[i-1]));
         rem_in[i] = fit ? (trial - REM_W'(div_ff[i-1])) : trial;
         quo_in[i] = {quo_ff[i-1][Q_BITS-2:0], fit};
         low_in[i] = {low_ff[i-1][Q_BITS-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0] <= rem0;
         low_ff[0] <= num[Q_BITS-1:0];
         quo_ff[0] <= '0;
         div_ff[0] <= div0;
         ovf_ff[0] <= (rem0 >= REM_W'(div0));
         neg_ff[0] <= in_mix.applied_throttle[TILT_W-1];
         pay_ff[0] <= in_mix;
         for (int i = 1; i <= Q_BITS; i++) begin
            rem_ff[i] <= rem_in[i];
            low_ff[i] <= low_in[i];
            quo_ff[i] <= quo_in[i];
            div_ff[i] <= div_ff[i-1];
            ovf_ff[i] <= ovf_ff[i-1];
            neg_ff[i] <= neg_ff[i-1];
            pay_ff[i] <= pay_ff[i-1];
         end
      end
   end

   // Sign, saturation and the result register.
   logic [Q_BITS-1:0]        q;
   logic signed [TILT_W-1:0] uncomp;
   rsp_type                  rsp_in, rsp_ff;
   logic                     rsp_valid_ff;

   always_comb begin
      q = quo_ff[Q_BITS];
      if (neg_ff[Q_BITS]) begin
         if (ovf_ff[Q_BITS] || (q[Q_BITS-1] && (q[Q_BITS-2:0] != '0))) begin
            uncomp = T_MIN;
         end else begin
            uncomp = TILT_W'(0) - $signed(q);
         end
      end else begin
         if (ovf_ff[Q_BITS] || q[Q_BITS-1]) begin
            uncomp = T_MAX;
         end else begin
            uncomp = $signed(q);
         end
      end
      rsp_in.left_thrust            = pay_ff[Q_BITS].left_thrust;
      rsp_in.right_thrust           = pay_ff[Q_BITS].right_thrust;
      rsp_in.tail_thrust            = pay_ff[Q_BITS].tail_thrust;
      rsp_in.left_tilt              = pay_ff[Q_BITS].left_tilt;
      rsp_in.right_tilt             = pay_ff[Q_BITS].right_tilt;
      rsp_in.tail_tilt              = pay_ff[Q_BITS].tail_tilt;
      rsp_in.applied_throttle       = pay_ff[Q_BITS].applied_throttle;
      rsp_in.uncompensated_throttle = uncomp;
      rsp_in.throttle_low_hit       = pay_ff[Q_BITS].throttle_low_hit;
      rsp_in.throttle_high_hit      = pay_ff[Q_BITS].throttle_high_hit;
      rsp_in.attitude_limited       = pay_ff[Q_BITS].attitude_limited;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff     <= {valid_ff[Q_BITS-1:0], in_valid};
         rsp_valid_ff <= valid_ff[Q_BITS];
      end
      if (en) begin
         rsp_ff <= rsp_in;
      end
   end

   assign out_valid = rsp_valid_ff;
   assign out_rsp   = rsp_ff;

endmodule

`default_nettype wire

[test/tb_top.sv]
`default_nettype none

// Mixer scoreboard: predicts one result word per demand set and keeps the
// predictions in arrival order.
class mixer_scoreboard;
   tttm_pkg::rsp_type pending_words[$];
   int mismatch_count;
   int word_count;
   int excess_count;
   int low_count;

   // Fixed-point product, rounded to nearest with ties toward plus infinity.
   function automatic longint fx_mul(longint a, longint b);
      longint p;
      p = a * b + tttm_pkg::HALF;
      return p >>> tttm_pkg::FRAC_BITS;
   endfunction

   function automatic longint sat_s16(longint v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return v;
   endfunction

   function automatic longint clip_unit(longint v);
      if (v < 0) return 0;
      if (v > tttm_pkg::ONE) return tttm_pkg::ONE;
      return v;
   endfunction

   function automatic longint coef(longint n, longint d);
      return (n * tttm_pkg::ONE * 2 + d) / (2 * d);
   endfunction

   function automatic longint floor_div(longint a, longint b);
      longint q;
      q = a / b;
      if ((a % b) != 0 && a < 0) q = q - 1;
      return q;
   endfunction

   // Work out the result word for one accepted demand set.
   function void note_demand(tttm_pkg::req_type d);
      longint gain, roll, pitch, yaw, thr, ceil_v, angle, mw, sw;
      longint tl, tr, tt, al, ar, at, tmax, adj, applied, dv;
      tttm_pkg::rsp_type w;
      w = '0;
      adj = 0;
      gain = longint'(d.supply_gain);
      roll = fx_mul(longint'(d.roll_demand) + longint'(d.roll_feedforward), gain);
      pitch = fx_mul(longint'(d.pitch_demand) + longint'(d.pitch_feedforward), gain);
      yaw = fx_mul(longint'(d.yaw_demand) + longint'(d.yaw_feedforward), gain);
      thr = fx_mul(longint'(d.throttle_demand), gain);
      ceil_v = longint'(d.throttle_ceiling);
      angle = floor_div((longint'(d.tilt_stick_pulse) - 1500) * tttm_pkg::ONE * 2 + 500,
                        1000);
      sw = angle >= 0 ? angle : -angle;
      mw = tttm_pkg::ONE - sw;
      if (thr <= 0) begin
         thr = 0;
         w.throttle_low_hit = 1'b1;
      end
      if (thr >= ceil_v) begin
         thr = ceil_v;
         w.throttle_high_hit = 1'b1;
      end
      tl = thr + fx_mul(fx_mul(mw, pitch), coef(4, 10)) - fx_mul(roll, coef(45, 100));
      tr = thr + fx_mul(fx_mul(mw, pitch), coef(4, 10)) + fx_mul(roll, coef(45, 100));
      tt = thr - fx_mul(fx_mul(mw, pitch), coef(6, 10));
      yaw = yaw - fx_mul(fx_mul(sw, yaw), coef(4, 10));
      // Pitch-term tilt coefficients depend on the tilt direction.
      if (angle <= 0) begin
         al = -fx_mul(angle, coef(7, 10)) - fx_mul(fx_mul(sw, pitch), coef(2, 10))
              - fx_mul(yaw, coef(3, 10));
         ar = fx_mul(angle, coef(7, 10)) + fx_mul(fx_mul(sw, pitch), coef(2, 10))
              - fx_mul(yaw, coef(3, 10));
         at = fx_mul(angle, coef(7, 10)) - fx_mul(fx_mul(sw, pitch), coef(5, 10));
      end else begin
         al = -fx_mul(angle, coef(7, 10)) + fx_mul(fx_mul(sw, pitch), coef(3, 10))
              - fx_mul(yaw, coef(3, 10));
         ar = fx_mul(angle, coef(7, 10)) - fx_mul(fx_mul(sw, pitch), coef(3, 10))
              - fx_mul(yaw, coef(3, 10));
         at = fx_mul(angle, coef(7, 10)) + fx_mul(fx_mul(sw, pitch), coef(4, 10));
      end
      // A side thrust above 1.0 lowers the thrusts and the applied throttle by the excess.
      tmax = tr > tl ? tr : tl;
      if (tmax > tttm_pkg::ONE) begin
         adj = tttm_pkg::ONE - tmax;
         w.throttle_high_hit = 1'b1;
         w.attitude_limited = 1'b1;
         excess_count++;
      end
      if (w.throttle_low_hit) low_count++;
      applied = sat_s16(thr + adj);
      dv = gain > 0 ? gain : 1;
      w.left_thrust = 13'(clip_unit(tl + adj));
      w.right_thrust = 13'(clip_unit(tr + adj));
      w.tail_thrust = 13'(clip_unit(tt + adj));
      w.left_tilt = 16'(sat_s16(al));
      w.right_tilt = 16'(sat_s16(ar));
      w.tail_tilt = 16'(sat_s16(at));
      w.applied_throttle = 16'(applied);
      w.uncompensated_throttle = 16'(sat_s16((applied * tttm_pkg::ONE) / dv));
      pending_words.push_back(w);
   endfunction

   function void report_field(string name, longint e, longint a);
      $display("%0t: mismatch on %s: expected %0d, actual %0d", $time, name, e, a);
      mismatch_count++;
   endfunction

   // Compare one result word with the oldest prediction.
   function void check_word(tttm_pkg::rsp_type a);
      tttm_pkg::rsp_type e;
      word_count++;
      if (pending_words.size() == 0) begin
         $display("%0t: result word arrived with nothing expected", $time);
         mismatch_count++;
         return;
      end
      e = pending_words.pop_front();
      if (e.left_thrust != a.left_thrust)
         report_field("left_thrust", longint'(e.left_thrust), longint'(a.left_thrust));
      if (e.right_thrust != a.right_thrust)
         report_field("right_thrust", longint'(e.right_thrust), longint'(a.right_thrust));
      if (e.tail_thrust != a.tail_thrust)
         report_field("tail_thrust", longint'(e.tail_thrust), longint'(a.tail_thrust));
      if (e.left_tilt != a.left_tilt)
         report_field("left_tilt", longint'(e.left_tilt), longint'(a.left_tilt));
      if (e.right_tilt != a.right_tilt)
         report_field("right_tilt", longint'(e.right_tilt), longint'(a.right_tilt));
      if (e.tail_tilt != a.tail_tilt)
         report_field("tail_tilt", longint'(e.tail_tilt), longint'(a.tail_tilt));
      if (e.applied_throttle != a.applied_throttle)
         report_field("applied_throttle", longint'(e.applied_throttle),
                      longint'(a.applied_throttle));
      if (e.uncompensated_throttle != a.uncompensated_throttle)
         report_field("uncompensated_throttle", longint'(e.uncompensated_throttle),
                      longint'(a.uncompensated_throttle));
      if (e.throttle_low_hit != a.throttle_low_hit)
         report_field("throttle_low_hit", longint'(e.throttle_low_hit),
                      longint'(a.throttle_low_hit));
      if (e.throttle_high_hit != a.throttle_high_hit)
         report_field("throttle_high_hit", longint'(e.throttle_high_hit),
                      longint'(a.throttle_high_hit));
      if (e.attitude_limited != a.attitude_limited)
         report_field("attitude_limited", longint'(e.attitude_limited),
                      longint'(a.attitude_limited));
   endfunction
endclass

module tb_top;
   import tttm_pkg::*;

   localparam int PIPE_DEPTH  = 25;
   localparam int CYCLE_LIMIT = 400000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_type demand_word = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   wire rsp_type result_word;
   int cycle_count = 0;
   int stall_left = 0;
   mixer_scoreboard mix_board;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   tilt_tricopter_thrust_mixer_top dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_roll_demand(demand_word.roll_demand),
      .req_roll_feedforward(demand_word.roll_feedforward),
      .req_pitch_demand(demand_word.pitch_demand),
      .req_pitch_feedforward(demand_word.pitch_feedforward),
      .req_yaw_demand(demand_word.yaw_demand),
      .req_yaw_feedforward(demand_word.yaw_feedforward),
      .req_throttle_demand(demand_word.throttle_demand),
      .req_throttle_ceiling(demand_word.throttle_ceiling),
      .req_supply_gain(demand_word.supply_gain),
      .req_tilt_stick_pulse(demand_word.tilt_stick_pulse),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_left_thrust(result_word.left_thrust),
      .rsp_right_thrust(result_word.right_thrust),
      .rsp_tail_thrust(result_word.tail_thrust),
      .rsp_left_tilt(result_word.left_tilt),
      .rsp_right_tilt(result_word.right_tilt),
      .rsp_tail_tilt(result_word.tail_tilt),
      .rsp_applied_throttle(result_word.applied_throttle),
      .rsp_uncompensated_throttle(result_word.uncompensated_throttle),
      .rsp_throttle_low_hit(result_word.throttle_low_hit),
      .rsp_throttle_high_hit(result_word.throttle_high_hit),
      .rsp_attitude_limited(result_word.attitude_limited)
   );

   // Mostly short gaps, now and then a long one.
   function automatic int gap_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Present one demand word and hold it until the block takes it.
   task automatic send_demand(req_type d);
      int gap;
      gap = gap_length();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      demand_word <= d;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      mix_board.note_demand(d);
   endtask

   function automatic req_type random_demand();
      req_type d;
      int r;
      d.roll_demand = 16'($urandom());
      d.roll_feedforward = 16'($urandom());
      d.pitch_demand = 16'($urandom());
      d.pitch_feedforward = 16'($urandom());
      d.yaw_demand = 16'($urandom());
      d.yaw_feedforward = 16'($urandom());
      r = $urandom_range(0, 9);
      // Most sets look like flight: small demands near hover.
      if (r < 6) begin
         d.roll_demand = $signed(16'($urandom_range(0, 4096))) - 16'sd2048;
         d.roll_feedforward = $signed(16'($urandom_range(0, 1024))) - 16'sd512;
         d.pitch_demand = $signed(16'($urandom_range(0, 4096))) - 16'sd2048;
         d.pitch_feedforward = $signed(16'($urandom_range(0, 1024))) - 16'sd512;
         d.yaw_demand = $signed(16'($urandom_range(0, 4096))) - 16'sd2048;
         d.yaw_feedforward = $signed(16'($urandom_range(0, 1024))) - 16'sd512;
         d.throttle_demand = 13'($urandom_range(0, 4096));
         d.throttle_ceiling = 13'($urandom_range(2048, 4096));
         d.supply_gain = 14'($urandom_range(3500, 6000));
         d.tilt_stick_pulse = 12'($urandom_range(800, 2200));
      end else begin
         d.throttle_demand = 13'($urandom());
         d.throttle_ceiling = 13'($urandom());
         d.supply_gain = 14'($urandom());
         d.tilt_stick_pulse = 12'($urandom());
      end
      return d;
   endfunction

   function automatic req_type make_demand(int dem, int ff, int thr, int ceil_v, int gain,
                                           int pulse);
      req_type d;
      d.roll_demand = 16'(dem);
      d.roll_feedforward = 16'(ff);
      d.pitch_demand = 16'(dem);
      d.pitch_feedforward = 16'(ff);
      d.yaw_demand = 16'(-dem);
      d.yaw_feedforward = 16'(ff);
      d.throttle_demand = 13'(thr);
      d.throttle_ceiling = 13'(ceil_v);
      d.supply_gain = 14'(gain);
      d.tilt_stick_pulse = 12'(pulse);
      return d;
   endfunction

   // Result side: stall runs of random length, check every accepted word.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) mix_board.check_word(result_word);
         if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left <= stall_left - 1;
         end else if ($urandom_range(0, 99) < 30) begin
            rsp_stall <= 1'b1;
            stall_left <= gap_length();
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   initial begin
      req_type d;
      int wait_count;
      mix_board = new();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed sets: field extremes, both tilt branches, clamps and excess.
      send_demand(make_demand(0, 0, 0, 0, 0, 1500));
      send_demand(make_demand(0, 0, 4096, 0, 4096, 1500));
      send_demand(make_demand(0, 0, 2048, 4096, 4096, 1500));
      send_demand(make_demand(32767, 32767, 8191, 8191, 16383, 4095));
      send_demand(make_demand(-32768, -32768, 8191, 8191, 16383, 0));
      send_demand(make_demand(4096, 0, 4096, 4096, 4096, 2200));
      send_demand(make_demand(-4096, 0, 4096, 4096, 4096, 800));
      send_demand(make_demand(2048, 1024, 3000, 4096, 4096, 1499));
      send_demand(make_demand(2048, 1024, 3000, 4096, 4096, 1501));
      send_demand(make_demand(1000, -500, 4096, 4096, 1, 1500));
      send_demand(make_demand(-2000, 300, 100, 4096, 16383, 1750));
      send_demand(make_demand(0, 0, 4096, 4096, 8191, 1500));
      send_demand(make_demand(12000, 0, 4000, 4096, 4096, 1200));
      send_demand(make_demand(-12000, 0, 4000, 4096, 4096, 1900));
      send_demand(make_demand(100, 100, 1, 1, 2, 2048));
      send_demand(make_demand(-1, 0, 0, 4096, 16383, 1500));

      // Hold off until every prediction has come back.
      req_valid <= 1'b0;
      wait_count = 0;
      while (mix_board.pending_words.size() != 0 && wait_count < 20000) begin
         @(posedge clock);
         wait_count++;
      end

      for (int i = 0; i < 740; i++) begin
         d = random_demand();
         send_demand(d);
      end
      req_valid <= 1'b0;

      // Drain, then keep watching for stray words.
      wait_count = 0;
      while (mix_board.pending_words.size() != 0 && wait_count < 50000) begin
         @(posedge clock);
         wait_count++;
      end
      repeat (PIPE_DEPTH * 4) @(posedge clock);

      $display("Covered %0d result words, %0d with thrust excess, %0d with zero throttle.",
               mix_board.word_count, mix_board.excess_count, mix_board.low_count);
      if (mix_board.mismatch_count == 0 && mix_board.pending_words.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("%0d mismatches, %0d words never arrived", mix_board.mismatch_count,
                  mix_board.pending_words.size());
         $display("Test completed with failures");
      end
      $finish;
   end
endmodule

`default_nettype wire
